/* rtl/strmi_pkg.sv */
// Shared types and constants for the sparse-table range-minimum-index block.
// Holds the transfer payload structs, the sequencer state type and the control
// structs that pass between the sequencer and the datapath. No dependencies.
`default_nettype none

package strmi_pkg;

    localparam int unsigned IDX_W = 10;
    localparam int unsigned VAL_W = 32;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic             func;
        logic signed [VAL_W-1:0] value;
        logic             last;
        logic [IDX_W-1:0] left_index;
        logic [IDX_W-1:0] right_index;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] min_index;
        logic             error;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_LVL0,
        S_B_VAL0,
        S_B_CHK,
        S_B_TAB,
        S_B_VAL,
        S_Q_LEV,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_VA,
        S_Q_VB,
        S_Q_CMP,
        S_EMIT
    } t_state;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic in_fire;
        logic is_load;
        logic is_last;
        logic q_err;
        logic lvl_more;
        logic pos_more;
        logic out_free;
    } t_stat;

    // Step strobes from the sequencer to the datapath.
    typedef struct packed {
        logic busy;
        logic b_lvl0;
        logic b_val0;
        logic b_chk;
        logic b_tab;
        logic b_val;
        logic q_lev;
        logic q_rda;
        logic q_rdb;
        logic q_va;
        logic q_vb;
        logic q_cmp;
        logic emit;
    } t_ctl;

endpackage

`default_nettype wire

/* rtl/strmi_cmp.sv */
// Shared signed compare unit of the range-minimum block.
// Used by both the table build and the query; depends on strmi_pkg.
`default_nettype none

module strmi_cmp (
    input  wire strmi_pkg::t_val i_a,
    input  wire strmi_pkg::t_val i_b,
    output logic                 o_less
);

    // Two's complement order: a strictly below b.
    assign o_less = (i_a < i_b);

endmodule

`default_nettype wire

/* rtl/strmi_ctrl.sv */
// Sequencer of the range-minimum block: steps the build and query walks.
// Reads datapath status and drives one strobe per step; depends on strmi_pkg.
`default_nettype none

module strmi_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire strmi_pkg::t_stat i_stat,
    output strmi_pkg::t_ctl       o_ctl
);

    strmi_pkg::t_state r_state;
    strmi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= strmi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            strmi_pkg::S_IDLE: begin
                if (i_stat.in_fire) begin
                    if (i_stat.is_load) begin
                        n_state = i_stat.is_last ? strmi_pkg::S_B_LVL0 : strmi_pkg::S_IDLE;
                    end else begin
                        n_state = i_stat.q_err ? strmi_pkg::S_EMIT : strmi_pkg::S_Q_LEV;
                    end
                end
            end
            strmi_pkg::S_B_LVL0: n_state = strmi_pkg::S_B_VAL0;
            strmi_pkg::S_B_VAL0: n_state = strmi_pkg::S_B_CHK;
            strmi_pkg::S_B_CHK: begin
                if (i_stat.lvl_more) begin
                    n_state = strmi_pkg::S_B_TAB;
                end else if (i_stat.pos_more) begin
                    n_state = strmi_pkg::S_B_LVL0;
                end else begin
                    n_state = strmi_pkg::S_IDLE;
                end
            end
            strmi_pkg::S_B_TAB: n_state = strmi_pkg::S_B_VAL;
            strmi_pkg::S_B_VAL: n_state = strmi_pkg::S_B_CHK;
            strmi_pkg::S_Q_LEV: n_state = strmi_pkg::S_Q_RDA;
            strmi_pkg::S_Q_RDA: n_state = strmi_pkg::S_Q_RDB;
            strmi_pkg::S_Q_RDB: n_state = strmi_pkg::S_Q_VA;
            strmi_pkg::S_Q_VA:  n_state = strmi_pkg::S_Q_VB;
            strmi_pkg::S_Q_VB:  n_state = strmi_pkg::S_Q_CMP;
            strmi_pkg::S_Q_CMP: n_state = strmi_pkg::S_EMIT;
            strmi_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = strmi_pkg::S_IDLE;
                end
            end
            default: n_state = strmi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.busy = 1'b1;
        unique case (r_state)
            strmi_pkg::S_IDLE:   o_ctl.busy   = 1'b0;
            strmi_pkg::S_B_LVL0: o_ctl.b_lvl0 = 1'b1;
            strmi_pkg::S_B_VAL0: o_ctl.b_val0 = 1'b1;
            strmi_pkg::S_B_CHK:  o_ctl.b_chk  = 1'b1;
            strmi_pkg::S_B_TAB:  o_ctl.b_tab  = 1'b1;
            strmi_pkg::S_B_VAL:  o_ctl.b_val  = 1'b1;
            strmi_pkg::S_Q_LEV:  o_ctl.q_lev  = 1'b1;
            strmi_pkg::S_Q_RDA:  o_ctl.q_rda  = 1'b1;
            strmi_pkg::S_Q_RDB:  o_ctl.q_rdb  = 1'b1;
            strmi_pkg::S_Q_VA:   o_ctl.q_va   = 1'b1;
            strmi_pkg::S_Q_VB:   o_ctl.q_vb   = 1'b1;
            strmi_pkg::S_Q_CMP:  o_ctl.q_cmp  = 1'b1;
            strmi_pkg::S_EMIT:   o_ctl.emit   = 1'b1;
            default:             o_ctl.busy   = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/sparse_table_range_min_index_core.sv */
// Top level of the sparse-table range-minimum-index block: datapath, value and
// table memories, input capture and output register. Depends on strmi_pkg,
// strmi_cmp and strmi_ctrl.
//
// Usage: send loads (func = 0) one value per transfer; a load marked last fixes
// the array length and starts the table build. A load that follows a build
// starts a new array at position 0; loads past DEPTH elements are dropped. A
// query (func = 1) names two positions in either order and returns the
// position of the minimum in that range; on a tie between the two covering
// windows the right one wins. A query before any build or with a position at
// or past the length returns error = 1 and min_index = 0.
// Timing: every memory has one read port with a registered output, and the
// sequencer walks one read at a time through them. A load without last does
// not stall the input. A load with last then builds the table for each
// position p up to level L(p) = min(LEVELS-1, floor(log2(p+1))). A query,
// valid or erroneous, ends in an emit step that waits while the output is
// stalled. The input is stalled for the whole build or query. No clearing
// pass runs after reset.
`default_nettype none

module sparse_table_range_min_index_core #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned LEVELS = 11
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire strmi_pkg::t_in i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output strmi_pkg::t_out     o_out_data
);

    localparam int unsigned IW     = $clog2(DEPTH);
    localparam int unsigned LW     = $clog2(DEPTH + 1);
    localparam int unsigned QW     = (LW > strmi_pkg::IDX_W) ? LW : strmi_pkg::IDX_W;
    localparam int unsigned KW     = $clog2(LEVELS);
    localparam int unsigned KW1    = $clog2(LEVELS + 1);
    localparam int unsigned WW     = LEVELS + 1;
    localparam int unsigned CW     = (WW > LW) ? WW : LW;
    localparam int unsigned SW     = $clog2(LW);
    localparam int unsigned TAW    = KW + IW;
    localparam int unsigned TDEPTH = LEVELS * (1 << IW);

    strmi_pkg::t_ctl  ctl;
    strmi_pkg::t_stat stat;

    // Memories: values by position, table by {level, position}.
    logic [strmi_pkg::VAL_W-1:0] r_vmem [0:DEPTH-1];
    logic [IW-1:0]               r_tmem [0:TDEPTH-1];
    logic [strmi_pkg::VAL_W-1:0] r_vrd;
    logic [IW-1:0]               r_trd;

    // Control state.
    logic [LW-1:0]  r_len;
    logic           r_built;
    logic           r_out_valid;
    strmi_pkg::t_out r_out;

    // Walk registers of build and query; r_k, r_win, r_cur, r_left and r_acc are shared.
    logic [IW-1:0]  r_p;
    logic [KW1-1:0] r_k;
    logic [WW-1:0]  r_win;
    logic [IW-1:0]  r_cur;
    logic [IW-1:0]  r_left;
    strmi_pkg::t_val r_acc;
    logic [IW-1:0]  r_lo;
    logic [IW-1:0]  r_hi;
    logic           r_err;
    logic [IW-1:0]  r_res;

    logic           in_fire;
    logic           is_load;
    logic [LW-1:0]  len0;
    logic           room;
    logic [QW-1:0]  lo_q;
    logic [QW-1:0]  hi_q;
    logic           q_err;
    logic [LW-1:0]  p1;
    logic           lvl_more;
    logic           pos_more;
    logic           out_free;
    logic [LW-1:0]  span;
    logic [SW-1:0]  kraw;
    logic [KW1-1:0] kq;
    logic [KW1-1:0] km1;
    logic           less;
    logic [IW-1:0]  sel;

    logic                        v_we;
    logic [IW-1:0]               v_waddr;
    logic [IW-1:0]               v_raddr;
    logic                        t_we;
    logic [TAW-1:0]              t_waddr;
    logic [IW-1:0]               t_wdata;
    logic [TAW-1:0]              t_raddr;

    strmi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    // One compare serves both walks: held value against the fresh read.
    strmi_cmp u_cmp (
        .i_a    (r_acc),
        .i_b    ($signed(r_vrd)),
        .o_less (less)
    );

    assign o_in_stall  = ctl.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire  = i_in_valid && !ctl.busy;
    assign is_load  = (i_in_data.func == strmi_pkg::FUNC_LOAD);
    assign out_free = !r_out_valid || !i_out_stall;

    // A load after a build starts over at position 0.
    assign len0 = r_built ? '0 : r_len;
    assign room = (len0 < LW'(DEPTH));

    assign lo_q  = QW'(i_in_data.left_index);
    assign hi_q  = QW'(i_in_data.right_index);
    assign q_err = !r_built || (lo_q >= QW'(r_len)) || (hi_q >= QW'(r_len));

    // Build: another level fits while below LEVELS and the window ending at p starts inside [0, p].
    assign p1       = LW'(r_p) + LW'(1);
    assign lvl_more = (r_k < KW1'(LEVELS)) && (CW'(r_win) <= CW'(p1));
    assign pos_more = (p1 < r_len);
    assign km1      = r_k - KW1'(1);

    // Query level: floor(log2(span)), capped at the top level.
    assign span = LW'(r_hi) - LW'(r_lo) + LW'(1);

    always_comb begin
        kraw = '0;
        for (int i = 0; i < LW; i++) begin
            if (span[i]) begin
                kraw = SW'(i);
            end
        end
        if (int'(kraw) > int'(LEVELS) - 1) begin
            kq = KW1'(LEVELS - 1);
        end else begin
            kq = KW1'(kraw);
        end
    end

    // Keep the held index on a strict win, else take the other one.
    assign sel = less ? r_cur : r_left;

    assign stat = '{
        in_fire:  in_fire,
        is_load:  is_load,
        is_last:  i_in_data.last,
        q_err:    q_err,
        lvl_more: lvl_more,
        pos_more: pos_more,
        out_free: out_free
    };

    // Value memory ports.
    assign v_we    = in_fire && is_load && room;
    assign v_waddr = len0[IW-1:0];

    always_comb begin
        v_raddr = r_p;
        if (ctl.b_tab) begin
            v_raddr = r_trd;
        end else if (ctl.q_va) begin
            v_raddr = r_cur;
        end else if (ctl.q_vb) begin
            v_raddr = r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[v_waddr] <= i_in_data.value;
        end
        r_vrd <= r_vmem[v_raddr];
    end

    // Table memory ports.
    assign t_we    = ctl.b_lvl0 || ctl.b_val;
    assign t_waddr = ctl.b_lvl0 ? {KW'(0), r_p} : {r_k[KW-1:0], r_p};
    assign t_wdata = ctl.b_lvl0 ? r_p : sel;

    always_comb begin
        t_raddr = {r_k[KW-1:0], r_hi};
        if (ctl.b_chk) begin
            t_raddr = {km1[KW-1:0], r_p - IW'(r_win >> 1)};
        end else if (ctl.q_rda) begin
            t_raddr = {r_k[KW-1:0], r_lo + IW'(r_win) - IW'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_waddr] <= t_wdata;
        end
        r_trd <= r_tmem[t_raddr];
    end

    // Length and build flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_built <= 1'b0;
        end else if (in_fire && is_load) begin
            r_built <= 1'b0;
            r_len   <= room ? (len0 + LW'(1)) : len0;
        end else if (ctl.b_chk && !lvl_more && !pos_more) begin
            r_built <= 1'b1;
        end
    end

    // Walk datapath.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (is_load) begin
                r_p <= '0;
            end else begin
                r_err <= q_err;
                r_res <= '0;
                // Swap a reversed range.
                if (lo_q > hi_q) begin
                    r_lo <= IW'(i_in_data.right_index);
                    r_hi <= IW'(i_in_data.left_index);
                end else begin
                    r_lo <= IW'(i_in_data.left_index);
                    r_hi <= IW'(i_in_data.right_index);
                end
            end
        end
        if (ctl.b_lvl0) begin
            r_k   <= KW1'(1);
            r_win <= WW'(2);
        end
        if (ctl.b_val0) begin
            r_acc <= $signed(r_vrd);
            r_cur <= r_p;
        end
        if (ctl.b_chk && !lvl_more && pos_more) begin
            r_p <= r_p + IW'(1);
        end
        if (ctl.b_tab) begin
            r_left <= r_trd;
        end
        if (ctl.b_val) begin
            r_cur <= sel;
            if (!less) begin
                r_acc <= $signed(r_vrd);
            end
            r_k   <= r_k + KW1'(1);
            r_win <= r_win << 1;
        end
        if (ctl.q_lev) begin
            r_k   <= kq;
            r_win <= WW'(1) << kq;
        end
        if (ctl.q_rdb) begin
            r_cur <= r_trd;
        end
        if (ctl.q_va) begin
            r_left <= r_trd;
        end
        if (ctl.q_vb) begin
            r_acc <= $signed(r_vrd);
        end
        if (ctl.q_cmp) begin
            r_res <= sel;
        end
    end

    // Output register: hold until the transfer, load a new result when free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit && out_free) begin
            r_out.min_index <= strmi_pkg::IDX_W'(r_res);
            r_out.error     <= r_err;
        end
    end

endmodule

`default_nettype wire

/* rtl/strmi_chk.sv */
// Port-level checker for the range-minimum block, bound to the top level.
// Sees only the top-level ports; depends on strmi_pkg.
`default_nettype none

module strmi_chk (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire strmi_pkg::t_in  i_in_data,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire strmi_pkg::t_out o_out_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A query occupies the block for at least the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.func == strmi_pkg::FUNC_QUERY)
        |=> o_in_stall)
        else $error("query transfer did not stall the input");

    // A plain load leaves the input unstalled in the next cycle.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.func == strmi_pkg::FUNC_LOAD)
        && !i_in_data.last |=> !o_in_stall)
        else $error("load without last kept the input stalled");

    // An error result carries index zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> (o_out_data.min_index == '0))
        else $error("error result with nonzero index");

endmodule

bind sparse_table_range_min_index_core strmi_chk u_strmi_chk (.*);

`default_nettype wire
